// ===== sv/sms_pkg.sv =====
// Shared types and constants for the startup map selector.
// Used by the top level, the selector core and the result buffer.
// No dependencies.
package sms_pkg;

    // Number of selectable maps (2 to 4)
    localparam int MAP_COUNT = 4;

    // Configuration register indexes
    localparam logic [2:0] CFG_TPS_THRESHOLD  = 3'd0;
    localparam logic [2:0] CFG_CONFIRM_HOLD   = 3'd1;
    localparam logic [2:0] CFG_TIMEOUT        = 3'd2;
    localparam logic [2:0] CFG_DEBOUNCE       = 3'd3;
    localparam logic [2:0] CFG_FLASH          = 3'd4;
    localparam logic [2:0] CFG_CLUTCH_POL     = 3'd5;

    // Exit cause codes
    localparam logic [1:0] EXIT_NONE    = 2'd0;
    localparam logic [1:0] EXIT_BOOT    = 2'd1;
    localparam logic [1:0] EXIT_TIMEOUT = 2'd2;
    localparam logic [1:0] EXIT_CONFIRM = 2'd3;

    // Configuration register set
    typedef struct packed {
        logic [6:0]  tps_threshold;
        logic [15:0] confirm_hold_ms;
        logic [15:0] timeout_ms;
        logic [7:0]  settle_ms;
        logic [9:0]  flash_ms;
        logic        clutch_active_high;
    } cfg_t;

    // One result item
    typedef struct packed {
        logic [1:0]  selected_map;
        logic [1:0]  applied_map;
        logic [11:0] shown_rpm;
        logic [2:0]  phase;
        logic [1:0]  exit_cause;
    } res_t;

endpackage

// ===== sv/sms_core.sv =====
// Selector core: per-tick state update and result computation.
// Depends on sms_pkg (cfg_t, res_t, MAP_COUNT, exit codes).
module sms_core (
    input  logic          clk,
    input  logic          rst_n,
    input  sms_pkg::cfg_t cfg,
    input  logic          push,
    input  logic          clutch_level,
    input  logic [9:0]    tps_raw,
    output sms_pkg::res_t result
);
    import sms_pkg::*;

    typedef enum logic [2:0] {
        PH_ENTRY    = 3'd0,
        PH_SELECT   = 3'd1,
        PH_DEBOUNCE = 3'd2,
        PH_FLASH    = 3'd3,
        PH_DONE     = 3'd4
    } phase_t;

    localparam logic [2:0] MAP_COUNT3 = 3'(MAP_COUNT);

    phase_t      phase_reg, phase_next;
    logic [1:0]  map_choice_reg, map_choice_next;
    logic [1:0]  map_applied_reg, map_applied_next;
    logic        last_clutch_reg, last_clutch_next;
    logic [15:0] idle_count_reg, idle_count_next;
    logic [15:0] hold_count_reg, hold_count_next;
    logic [7:0]  debounce_count_reg, debounce_count_next;
    logic [11:0] flash_count_reg, flash_count_next;
    logic [1:0]  exit_reg, exit_next;

    logic        pressed;
    logic        flash_zero;
    logic [15:0] idle_inc, hold_inc;
    logic [7:0]  dbc_inc;
    logic [12:0] fc_inc;
    logic [12:0] fm1, fm2, fm3, fm4;
    logic [16:0] tps_scaled, tps_limit;
    logic [2:0]  map_inc;
    logic [1:0]  map_adv;
    logic [11:0] shown;

    // Gauge value for a map: (map + 1) * 1000
    function automatic logic [11:0] rpm_of(input logic [1:0] m);
        logic [11:0] r;
        case (m)
            2'd0:    r = 12'd1000;
            2'd1:    r = 12'd2000;
            2'd2:    r = 12'd3000;
            default: r = 12'd4000;
        endcase
        return r;
    endfunction

    // Entry test: floor(raw*100/1023) > thr  <=>  raw*100 >= (thr+1)*1023
    assign tps_scaled = {7'd0, tps_raw} * 17'd100;
    assign tps_limit  = ({10'd0, cfg.tps_threshold} + 17'd1) * 17'd1023;

    // Flash phase boundaries
    assign fm1 = {3'd0, cfg.flash_ms};
    assign fm2 = {fm1[11:0], 1'b0};
    assign fm3 = fm2 + fm1;
    assign fm4 = {fm1[10:0], 2'b00};

    // Counter increments
    assign idle_inc = (idle_count_reg == 16'hFFFF) ? 16'hFFFF : idle_count_reg + 16'd1;
    assign hold_inc = (hold_count_reg == 16'hFFFF) ? 16'hFFFF : hold_count_reg + 16'd1;
    assign dbc_inc  = debounce_count_reg + 8'd1;
    assign fc_inc   = {1'b0, flash_count_reg} + 13'd1;

    // Map advance modulo the map count
    assign map_inc = {1'b0, map_choice_reg} + 3'd1;
    assign map_adv = (map_inc == MAP_COUNT3) ? 2'd0 : map_inc[1:0];

    assign pressed = (clutch_level == cfg.clutch_active_high);

    // Next-state logic for one tick
    always_comb
    begin
        phase_next          = phase_reg;
        map_choice_next     = map_choice_reg;
        map_applied_next    = map_applied_reg;
        last_clutch_next    = last_clutch_reg;
        idle_count_next     = idle_count_reg;
        hold_count_next     = hold_count_reg;
        debounce_count_next = debounce_count_reg;
        flash_count_next    = flash_count_reg;
        exit_next           = exit_reg;
        flash_zero          = 1'b0;

        case (phase_reg)
            PH_ENTRY:
            begin
                map_choice_next  = 2'd0;
                map_applied_next = 2'd0;
                if (tps_scaled >= tps_limit && pressed)
                begin
                    phase_next       = PH_SELECT;
                    last_clutch_next = 1'b1;
                    idle_count_next  = 16'd0;
                    hold_count_next  = 16'd0;
                end
                else
                begin
                    phase_next = PH_DONE;
                    exit_next  = EXIT_BOOT;
                end
            end
            PH_SELECT:
            begin
                idle_count_next = idle_inc;
                if (idle_inc >= cfg.timeout_ms)
                begin
                    // inactivity timeout
                    map_applied_next = 2'd0;
                    map_choice_next  = 2'd0;
                    exit_next        = EXIT_TIMEOUT;
                    phase_next       = PH_DONE;
                end
                else if (pressed && !last_clutch_reg)
                begin
                    // rising edge
                    last_clutch_next = 1'b1;
                    if (cfg.settle_ms == 8'd0)
                    begin
                        map_choice_next = map_adv;
                        idle_count_next = 16'd0;
                        hold_count_next = 16'd0;
                    end
                    else
                    begin
                        phase_next          = PH_DEBOUNCE;
                        debounce_count_next = 8'd0;
                    end
                end
                else
                begin
                    last_clutch_next = pressed;
                    if (pressed)
                    begin
                        hold_count_next = hold_inc;
                        if (hold_inc >= cfg.confirm_hold_ms)
                        begin
                            // confirm the chosen map
                            map_applied_next = map_choice_reg;
                            exit_next        = EXIT_CONFIRM;
                            if (cfg.flash_ms == 10'd0)
                            begin
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next       = PH_FLASH;
                                flash_count_next = 12'd0;
                                flash_zero       = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        hold_count_next = 16'd0;
                    end
                end
            end
            PH_DEBOUNCE:
            begin
                idle_count_next     = idle_inc;
                debounce_count_next = dbc_inc;
                if (dbc_inc >= cfg.settle_ms)
                begin
                    phase_next = PH_SELECT;
                    if (pressed)
                    begin
                        map_choice_next = map_adv;
                        idle_count_next = 16'd0;
                        hold_count_next = 16'd0;
                    end
                    else
                    begin
                        hold_count_next = 16'd0;
                    end
                end
            end
            PH_FLASH:
            begin
                flash_count_next = fc_inc[11:0];
                if (fc_inc >= fm4 || cfg.flash_ms == 10'd0)
                begin
                    phase_next = PH_DONE;
                end
                else
                begin
                    // zero in the first and third phase
                    flash_zero = (fc_inc < fm1) || (fc_inc >= fm2 && fc_inc < fm3);
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    // Gauge value from the updated state
    always_comb
    begin
        if (flash_zero)
            shown = 12'd0;
        else if (phase_next == PH_FLASH || phase_next == PH_DONE)
            shown = rpm_of(map_applied_next);
        else
            shown = rpm_of(map_choice_next);
    end

    assign result.selected_map = map_choice_next;
    assign result.applied_map  = map_applied_next;
    assign result.shown_rpm    = shown;
    assign result.phase        = phase_next;
    assign result.exit_cause   = exit_next;

    // State registers, updated on each accepted tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_ENTRY;
            map_choice_reg     <= 2'd0;
            map_applied_reg    <= 2'd0;
            last_clutch_reg    <= 1'b1;
            idle_count_reg     <= 16'd0;
            hold_count_reg     <= 16'd0;
            debounce_count_reg <= 8'd0;
            flash_count_reg    <= 12'd0;
            exit_reg           <= EXIT_NONE;
        end
        else if (push)
        begin
            phase_reg          <= phase_next;
            map_choice_reg     <= map_choice_next;
            map_applied_reg    <= map_applied_next;
            last_clutch_reg    <= last_clutch_next;
            idle_count_reg     <= idle_count_next;
            hold_count_reg     <= hold_count_next;
            debounce_count_reg <= debounce_count_next;
            flash_count_reg    <= flash_count_next;
            exit_reg           <= exit_next;
        end
    end

    // Finished is terminal
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |=> (phase_reg == PH_DONE && $stable(exit_reg)
            && $stable(map_applied_reg)))
        else $error("left finished phase");

    // Flashing only after a confirm
    a_flash_confirmed: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FLASH) |-> (exit_reg == EXIT_CONFIRM))
        else $error("flashing without confirm");

    // A nonzero applied map only comes from a confirm
    a_applied_confirmed: assert property (@(posedge clk) disable iff (!rst_n)
        (map_applied_reg != 2'd0) |-> (exit_reg == EXIT_CONFIRM))
        else $error("applied map set without confirm");

endmodule

// ===== sv/sms_out_buf.sv =====
// Two-entry result buffer: output register plus skid stage.
// Depends on sms_pkg (res_t).
module sms_out_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sms_pkg::res_t res_in,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output sms_pkg::res_t res_out
);
    import sms_pkg::*;

    logic out_valid_reg, skid_valid_reg;
    res_t out_data_reg, skid_data_reg;
    logic pop;

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign res_out   = out_data_reg;

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                out_valid_reg <= push;
        end
        else if (!out_valid_reg)
        begin
            out_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
            out_data_reg <= skid_data_reg;
        else if ((pop || !out_valid_reg) && push)
            out_data_reg <= res_in;
        if (!pop && out_valid_reg && push)
            skid_data_reg <= res_in;
    end

    // Skid holds data only behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid full with empty output");

    // A stalled result is not dropped
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("stalled result changed");

    // Skid drains into the output register on a take
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_ready) |=> (out_valid_reg && !skid_valid_reg
            && out_data_reg == $past(skid_data_reg)))
        else $error("skid did not drain");

endmodule

// ===== sv/startup_map_selector.sv =====
// Top level of the startup map selector: configuration registers,
// selector core and result buffer. Depends on sms_pkg, sms_core, sms_out_buf.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_ready, clutch_level, tps_raw | in
//  result  | out_valid, out_ready, selected_map,       | out
//          | applied_map, shown_rpm, phase, exit_cause |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// One tick per clock while in_ready is high: the state update is a single
// combinational pass from the input ports into the state and result registers
// (output register, or skid stage behind a stalled result). A two-entry
// result buffer lets a tick transfer while an earlier result is stalled.
// Reset (async, active low) restores register defaults and the entry-pending
// state. Config writes are always accepted and act from the next tick.
module startup_map_selector (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        clutch_level,
    input  logic [9:0]  tps_raw,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  selected_map,
    output logic [1:0]  applied_map,
    output logic [11:0] shown_rpm,
    output logic [2:0]  phase,
    output logic [1:0]  exit_cause,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sms_pkg::*;

    cfg_t cfg_reg;
    res_t core_res, buf_res;
    logic push;

    assign cfg_ready = 1'b1;
    assign push      = in_valid && in_ready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tps_threshold      <= 7'd90;
            cfg_reg.confirm_hold_ms    <= 16'd3000;
            cfg_reg.timeout_ms         <= 16'd10000;
            cfg_reg.settle_ms          <= 8'd50;
            cfg_reg.flash_ms           <= 10'd200;
            cfg_reg.clutch_active_high <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TPS_THRESHOLD: cfg_reg.tps_threshold      <= cfg_data[6:0];
                CFG_CONFIRM_HOLD:  cfg_reg.confirm_hold_ms    <= cfg_data;
                CFG_TIMEOUT:       cfg_reg.timeout_ms         <= cfg_data;
                CFG_DEBOUNCE:      cfg_reg.settle_ms          <= cfg_data[7:0];
                CFG_FLASH:         cfg_reg.flash_ms           <= cfg_data[9:0];
                CFG_CLUTCH_POL:    cfg_reg.clutch_active_high <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    sms_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .push         (push),
        .clutch_level (clutch_level),
        .tps_raw      (tps_raw),
        .result       (core_res)
    );

    sms_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .res_in    (core_res),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (buf_res)
    );

    assign selected_map = buf_res.selected_map;
    assign applied_map  = buf_res.applied_map;
    assign shown_rpm    = buf_res.shown_rpm;
    assign phase        = buf_res.phase;
    assign exit_cause   = buf_res.exit_cause;

endmodule
